[src/ncc_pkg.sv]
// Shared constants, status codes and controller/datapath handshake types.
`default_nettype none
package ncc_pkg;

   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int SUM_BITS  = 33;
   localparam int SQ_BITS   = 49;
   localparam int WORD_BITS = 64;
   localparam int PROD_BITS = 128;
   localparam int Q_BITS    = 63;
   localparam int REM_BITS  = 125;
   localparam int ROOT_BITS = 32;
   localparam int SREM_BITS = 34;

   localparam int MUL_STEPS  = 64;
   localparam int DIV_STEPS  = 63;
   localparam int SQRT_STEPS = 32;
   localparam int STEP_BITS  = 7;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FEW      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_VAR = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   // multiply operations, in issue order
   localparam logic [2:0] OP_N_SAA  = 3'd0;
   localparam logic [2:0] OP_SA_SA  = 3'd1;
   localparam logic [2:0] OP_N_SBB  = 3'd2;
   localparam logic [2:0] OP_SB_SB  = 3'd3;
   localparam logic [2:0] OP_N_SAB  = 3'd4;
   localparam logic [2:0] OP_SA_SB  = 3'd5;
   localparam logic [2:0] OP_VA_VB  = 3'd6;
   localparam logic [2:0] OP_C_C    = 3'd7;

   typedef struct packed {
      logic       take;
      logic       mul_load;
      logic       mul_step;
      logic       mul_store;
      logic [2:0] mul_op;
      logic       div_step;
      logic       sqrt_load;
      logic       sqrt_step;
      logic       emit;
      logic [1:0] emit_status;
   } ncc_cmd_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_last;
      logic overflowed;
      logic few;
      logic zero_var;
      logic out_free;
   } ncc_stat_type;

endpackage
`default_nettype wire

[src/ncc_req_if.sv]
// Sample-pair channel: valid/ready handshake with the pair and its last flag.
`default_nettype none
interface ncc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_a;
   logic [15:0] sample_b;
   logic        last;

   modport source (output valid, sample_a, sample_b, last, input ready);
   modport sink   (input valid, sample_a, sample_b, last, output ready);
endinterface
`default_nettype wire

[src/ncc_rsp_if.sv]
// Result channel: valid/ready handshake with the coefficient and status.
`default_nettype none
interface ncc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] correlation;
   logic [1:0]  status;

   modport source (output valid, correlation, status, input ready);
   modport sink   (input valid, correlation, status, output ready);
endinterface
`default_nettype wire

[src/normalized_cross_correlation.sv]
// Top level of the normalized cross-correlation block.
//
// Sample pairs arrive on req_bus (valid/ready); a transfer with last set
// closes the window. Pairs are taken one per cycle while ready is high and
// enter the running sums through an input register. After the last pair,
// ready drops while the result is worked out: a status check, eight
// multiplies on a shared shift-add unit, a restoring divide and a square
// root. Overflow and fewer than two pairs skip the rest; zero variance is
// known after the sixth multiply. One result per window leaves on rsp_bus
// from an output register; the next window's pairs are taken while it
// waits. If the receiver stalls, the result holds and a following window
// stops at its own result until the register frees up. Synchronous reset
// clears the sums, the sequencer and the output valid.
`default_nettype none
module normalized_cross_correlation
   import ncc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   ncc_req_if.sink    req_bus,
   ncc_rsp_if.source  rsp_bus
);

   ncc_cmd_type  cmd;
   ncc_stat_type stat;
   logic         ready;

   assign req_bus.ready = ready;

   ncc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ncc_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_sample_a    (req_bus.sample_a),
      .req_sample_b    (req_bus.sample_b),
      .req_last        (req_bus.last),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_correlation (rsp_bus.correlation),
      .rsp_status      (rsp_bus.status)
   );

endmodule
`default_nettype wire

[src/ncc_ctrl.sv]
// Sequencer: accumulate, then run the multiply, divide and root steps.
`default_nettype none
module ncc_ctrl
   import ncc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire ncc_stat_type stat,
   output      ncc_cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_ACCUM  = 9'b000000001,
      ST_CHECK  = 9'b000000010,
      ST_MLOAD  = 9'b000000100,
      ST_MRUN   = 9'b000001000,
      ST_MSTORE = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_SLOAD  = 9'b001000000,
      ST_SQRT   = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } ncc_state_type;

   ncc_state_type        state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [2:0]           op_ff, op_in;
   logic [1:0]           status_ff, status_in;

   assign req_ready = (state_ff == ST_ACCUM) && !(stat.s1_valid && stat.s1_last);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      op_in     = op_ff;
      status_in = status_ff;
      cmd             = '0;
      cmd.take        = req_valid && req_ready;
      cmd.mul_op      = op_ff;
      cmd.emit_status = status_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (stat.s1_valid && stat.s1_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.overflowed) begin
               status_in = STATUS_OVERFLOW;
               state_in  = ST_EMIT;
            end else if (stat.few) begin
               status_in = STATUS_FEW;
               state_in  = ST_EMIT;
            end else begin
               op_in    = OP_N_SAA;
               state_in = ST_MLOAD;
            end
         end
         ST_MLOAD: begin
            if (op_ff == OP_VA_VB && stat.zero_var) begin
               status_in = STATUS_ZERO_VAR;
               state_in  = ST_EMIT;
            end else begin
               cmd.mul_load = 1'b1;
               step_in      = '0;
               state_in     = ST_MRUN;
            end
         end
         ST_MRUN: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(MUL_STEPS - 1)) begin
               state_in = ST_MSTORE;
            end
         end
         ST_MSTORE: begin
            cmd.mul_store = 1'b1;
            step_in       = '0;
            if (op_ff == OP_C_C) begin
               state_in = ST_DIV;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_MLOAD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_SLOAD;
            end
         end
         ST_SLOAD: begin
            cmd.sqrt_load = 1'b1;
            step_in       = '0;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(SQRT_STEPS - 1)) begin
               status_in = STATUS_OK;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_ACCUM;
         step_ff   <= '0;
         op_ff     <= OP_N_SAA;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         op_ff     <= op_in;
         status_ff <= status_in;
      end
   end

endmodule
`default_nettype wire

[src/ncc_dp.sv]
// Datapath: running sums, shift-add multiplier, divider, square root, output register.
`default_nettype none
module ncc_dp
   import ncc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ncc_cmd_type  cmd,
   output      ncc_stat_type stat,
   input  wire logic [15:0]  req_sample_a,
   input  wire logic [15:0]  req_sample_b,
   input  wire logic         req_last,
   input  wire logic         rsp_ready,
   output      logic         rsp_valid,
   output      logic [31:0]  rsp_correlation,
   output      logic [1:0]   rsp_status
);

   localparam int CountBits = $clog2(MAX_SAMPLES + 1);

   // input stage
   logic        s1_valid_ff;
   logic        s1_last_ff;
   logic [15:0] s1_a_ff, s1_b_ff;

   // running sums
   logic [CountBits-1:0]       count_ff;
   logic                       overflowed_ff;
   logic signed [SUM_BITS-1:0] sum_a_ff, sum_b_ff;
   logic signed [SQ_BITS-1:0]  sumsq_a_ff, sumsq_b_ff, sum_ab_ff;

   logic signed [15:0] a_x, b_x;
   logic signed [31:0] aa, bb, ab;

   // multiplier
   logic [PROD_BITS-1:0]  mc_ff, acc_ff, prod;
   logic [WORD_BITS-1:0]  mp_ff;
   logic                  mneg_ff;
   logic signed [WORD_BITS-1:0] op_x, op_y;
   logic [WORD_BITS-1:0]  mag_x, mag_y;

   logic [WORD_BITS-1:0] tmp_ff, va_ff, vb_ff, magc_ff, c_diff;
   logic                 neg_ff;

   // divider
   logic [REM_BITS-1:0] p_ff, rem_ff;
   logic [Q_BITS-1:0]   quo_ff;
   logic [REM_BITS:0]   div_t, div_d;

   // square root
   logic [WORD_BITS-1:0] rad_ff;
   logic [ROOT_BITS-1:0] root_ff;
   logic [SREM_BITS-1:0] srem_ff;
   logic [SREM_BITS+1:0] sq_t, sq_trial;

   logic [ROOT_BITS:0]   half;
   logic [31:0]          mag_m, corr;

   logic        out_valid_ff;
   logic [31:0] out_corr_ff;
   logic [1:0]  out_status_ff;

   assign a_x = 16'(signed'(s1_a_ff[SAMPLE_BITS-1:0]));
   assign b_x = 16'(signed'(s1_b_ff[SAMPLE_BITS-1:0]));
   assign aa  = a_x * a_x;
   assign bb  = b_x * b_x;
   assign ab  = a_x * b_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.take;
      end
      if (cmd.take) begin
         s1_a_ff    <= req_sample_a;
         s1_b_ff    <= req_sample_b;
         s1_last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         count_ff      <= '0;
         overflowed_ff <= 1'b0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         sumsq_a_ff    <= '0;
         sumsq_b_ff    <= '0;
         sum_ab_ff     <= '0;
      end else if (s1_valid_ff) begin
         if (count_ff >= CountBits'(MAX_SAMPLES)) begin
            overflowed_ff <= 1'b1;
         end else begin
            count_ff   <= count_ff + 1'b1;
            sum_a_ff   <= sum_a_ff + SUM_BITS'(a_x);
            sum_b_ff   <= sum_b_ff + SUM_BITS'(b_x);
            sumsq_a_ff <= sumsq_a_ff + SQ_BITS'(aa);
            sumsq_b_ff <= sumsq_b_ff + SQ_BITS'(bb);
            sum_ab_ff  <= sum_ab_ff + SQ_BITS'(ab);
         end
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.mul_op)
         OP_N_SAA: begin
            op_x = signed'(WORD_BITS'(count_ff));
            op_y = WORD_BITS'(sumsq_a_ff);
         end
         OP_SA_SA: begin
            op_x = WORD_BITS'(sum_a_ff);
            op_y = WORD_BITS'(sum_a_ff);
         end
         OP_N_SBB: begin
            op_x = signed'(WORD_BITS'(count_ff));
            op_y = WORD_BITS'(sumsq_b_ff);
         end
         OP_SB_SB: begin
            op_x = WORD_BITS'(sum_b_ff);
            op_y = WORD_BITS'(sum_b_ff);
         end
         OP_N_SAB: begin
            op_x = signed'(WORD_BITS'(count_ff));
            op_y = WORD_BITS'(sum_ab_ff);
         end
         OP_SA_SB: begin
            op_x = WORD_BITS'(sum_a_ff);
            op_y = WORD_BITS'(sum_b_ff);
         end
         OP_VA_VB: begin
            op_x = signed'(va_ff);
            op_y = signed'(vb_ff);
         end
         default: begin
            op_x = signed'(magc_ff);
            op_y = signed'(magc_ff);
         end
      endcase
   end

   assign mag_x = op_x[WORD_BITS-1] ? WORD_BITS'(-op_x) : WORD_BITS'(op_x);
   assign mag_y = op_y[WORD_BITS-1] ? WORD_BITS'(-op_y) : WORD_BITS'(op_y);
   assign prod  = mneg_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign c_diff = tmp_ff - prod[WORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         mc_ff   <= PROD_BITS'(mag_x);
         mp_ff   <= mag_y;
         acc_ff  <= '0;
         mneg_ff <= op_x[WORD_BITS-1] ^ op_y[WORD_BITS-1];
      end else if (cmd.mul_step) begin
         if (mp_ff[0]) begin
            acc_ff <= acc_ff + mc_ff;
         end
         mc_ff <= mc_ff << 1;
         mp_ff <= mp_ff >> 1;
      end
   end

   assign div_t = {rem_ff, quo_ff[Q_BITS-1]};
   assign div_d = div_t - {1'b0, p_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul_store) begin
         case (cmd.mul_op)
            OP_N_SAA, OP_N_SBB, OP_N_SAB: tmp_ff <= prod[WORD_BITS-1:0];
            OP_SA_SA: va_ff <= c_diff;
            OP_SB_SB: vb_ff <= c_diff;
            OP_SA_SB: begin
               neg_ff  <= c_diff[WORD_BITS-1];
               magc_ff <= c_diff[WORD_BITS-1] ? (~c_diff + 1'b1) : c_diff;
            end
            OP_VA_VB: p_ff <= prod[REM_BITS-1:0];
            default: begin
               // dividend is c^2 * 2^62; its top part seeds the remainder
               rem_ff <= prod[REM_BITS:1];
               quo_ff <= {prod[0], {(Q_BITS-1){1'b0}}};
            end
         endcase
      end else if (cmd.div_step) begin
         if (div_t >= {1'b0, p_ff}) begin
            rem_ff <= div_d[REM_BITS-1:0];
            quo_ff <= {quo_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= div_t[REM_BITS-1:0];
            quo_ff <= {quo_ff[Q_BITS-2:0], 1'b0};
         end
      end
   end

   assign sq_t     = {srem_ff, rad_ff[WORD_BITS-1:WORD_BITS-2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         rad_ff  <= WORD_BITS'(quo_ff);
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= rad_ff << 2;
         if (sq_t >= sq_trial) begin
            srem_ff <= SREM_BITS'(sq_t - sq_trial);
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            srem_ff <= SREM_BITS'(sq_t);
            root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   // largest odd k <= isqrt(Q) gives magnitude (k+1)/2, capped at 1.0
   assign half  = (ROOT_BITS+1)'({1'b0, root_ff} + 1'b1) >> 1;
   assign mag_m = (half > (ROOT_BITS+1)'(33'h040000000)) ? 32'h40000000 : half[31:0];
   assign corr  = neg_ff ? (~mag_m + 1'b1) : mag_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_corr_ff   <= (cmd.emit_status == STATUS_OK) ? corr : 32'd0;
         out_status_ff <= cmd.emit_status;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_correlation = out_corr_ff;
   assign rsp_status      = out_status_ff;

   assign stat.s1_valid   = s1_valid_ff;
   assign stat.s1_last    = s1_last_ff;
   assign stat.overflowed = overflowed_ff;
   assign stat.few        = count_ff < CountBits'(2);
   assign stat.zero_var   = (va_ff == '0) || (vb_ff == '0);
   assign stat.out_free   = !out_valid_ff || rsp_ready;

endmodule
`default_nettype wire

[src/ncc_checker.sv]
// Port-level checks for the correlation block, bound to the top level.
`default_nettype none
module ncc_checker
   import ncc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_correlation,
   input wire logic [1:0]  rsp_status
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_correlation)
                                  && $stable(rsp_status))
      else $error("stalled result changed");

   // any failure status comes with a zero coefficient
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_correlation == 32'd0)
      else $error("nonzero coefficient with failure status");

   // coefficient stays within -1.0 .. +1.0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_correlation) <= 32'sh40000000) &&
                    ($signed(rsp_correlation) >= -32'sh40000000))
      else $error("coefficient out of range");

   // the block stops taking pairs right after the closing transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("pair taken after window close");

endmodule

bind normalized_cross_correlation ncc_checker u_ncc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_last        (req_bus.last),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_correlation (rsp_bus.correlation),
   .rsp_status      (rsp_bus.status)
);
`default_nettype wire
